// ----- hdl/stc_pkg.sv -----
// Shared types and constants for the space-run to tab compressor.
// Used by stc_ctrl, stc_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package stc_pkg;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [4:0] STOP_WIDTH_RESET = 5'd8;
  localparam logic [4:0] STOP_WIDTH_MAX   = 5'd16;

  // Source of the byte loaded into the output register
  typedef enum logic [1:0] {
    OUT_SPACE,
    OUT_TAB,
    OUT_BYTE_IN,
    OUT_BYTE_HELD
  } out_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     accept;
    logic     load_out;
    out_sel_t out_sel;
    logic     out_last;
    logic     dec_pending;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic end_item;
    logic space_item;
    logic wrap;
    logic pending_zero;
    logic pending_one;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/stc_datapath.sv -----
// Datapath of the space-run to tab compressor: width register, column,
// pending space count, held byte and the output register.
// Depends on stc_pkg; driven by commands from stc_ctrl.
`timescale 1ns / 1ps

module stc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  input  logic               out_ready,
  input  stc_pkg::cmd_t      cmd,
  output stc_pkg::status_t   sts,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               last_of_run
);

  logic [4:0] stop_width;
  logic [3:0] column;
  logic [3:0] pending;
  logic [7:0] held_byte;

  logic [4:0] eff_width;
  logic [4:0] col_inc;
  logic       wrap;
  logic [3:0] column_next;
  logic       is_space;
  logic       is_break;
  logic [7:0] out_byte_next;

  // Clamp the width into 1..16
  always_comb begin
    if (stop_width == 5'd0) begin
      eff_width = 5'd1;
    end else if (stop_width > stc_pkg::STOP_WIDTH_MAX) begin
      eff_width = stc_pkg::STOP_WIDTH_MAX;
    end else begin
      eff_width = stop_width;
    end
  end

  assign col_inc     = {1'b0, column} + 5'd1;
  assign wrap        = (col_inc >= eff_width);
  assign column_next = wrap ? 4'd0 : col_inc[3:0];
  assign is_space    = (text_byte == stc_pkg::CHAR_SPACE);
  assign is_break    = (text_byte == stc_pkg::CHAR_TAB) ||
                       (text_byte == stc_pkg::CHAR_NEWLINE);

  always_comb begin
    case (cmd.out_sel)
      stc_pkg::OUT_SPACE:     out_byte_next = stc_pkg::CHAR_SPACE;
      stc_pkg::OUT_TAB:       out_byte_next = stc_pkg::CHAR_TAB;
      stc_pkg::OUT_BYTE_IN:   out_byte_next = text_byte;
      stc_pkg::OUT_BYTE_HELD: out_byte_next = held_byte;
      default:                out_byte_next = held_byte;
    endcase
  end

  always_comb begin
    sts.end_item     = end_of_text;
    sts.space_item   = is_space;
    sts.wrap         = wrap;
    sts.pending_zero = (pending == 4'd0);
    sts.pending_one  = (pending == 4'd1);
    sts.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_width <= stc_pkg::STOP_WIDTH_RESET;
      column     <= 4'd0;
      pending    <= 4'd0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        stop_width <= cfg_wr_data;
      end
      if (cmd.accept) begin
        if (end_of_text) begin
          column <= 4'd0;
        end else if (is_space) begin
          column  <= column_next;
          pending <= wrap ? 4'd0 : pending + 4'd1;
        end else begin
          column <= is_break ? 4'd0 : column_next;
        end
      end else if (cmd.dec_pending) begin
        pending <= pending - 4'd1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      held_byte <= text_byte;
    end
    if (cmd.load_out) begin
      out_byte    <= out_byte_next;
      last_of_run <= cmd.out_last;
    end
  end

endmodule

// ----- hdl/stc_ctrl.sv -----
// Controller of the space-run to tab compressor: takes items, sequences
// the release of held spaces and the held byte.
// Depends on stc_pkg; commands stc_datapath.
`timescale 1ns / 1ps

module stc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  stc_pkg::status_t  sts,
  output stc_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_ACCEPT,
    S_SPACES,
    S_BYTE
  } state_t;

  state_t state;
  state_t state_next;
  logic   has_byte;
  logic   has_byte_next;
  logic   acc;

  assign in_ready = (state == S_ACCEPT) && sts.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_next      = state;
    has_byte_next   = has_byte;
    cmd.accept      = acc;
    cmd.load_out    = 1'b0;
    cmd.out_sel     = stc_pkg::OUT_SPACE;
    cmd.out_last    = 1'b0;
    cmd.dec_pending = 1'b0;
    case (state)
      S_ACCEPT: begin
        if (acc) begin
          if (sts.end_item) begin
            if (!sts.pending_zero) begin
              state_next    = S_SPACES;
              has_byte_next = 1'b0;
            end
          end else if (sts.space_item) begin
            if (sts.wrap) begin
              cmd.load_out = 1'b1;
              cmd.out_sel  = stc_pkg::OUT_TAB;
              cmd.out_last = 1'b1;
            end
          end else if (sts.pending_zero) begin
            cmd.load_out = 1'b1;
            cmd.out_sel  = stc_pkg::OUT_BYTE_IN;
            cmd.out_last = 1'b1;
          end else begin
            state_next    = S_SPACES;
            has_byte_next = 1'b1;
          end
        end
      end
      S_SPACES: begin
        if (sts.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.out_sel     = stc_pkg::OUT_SPACE;
          cmd.out_last    = sts.pending_one && !has_byte;
          cmd.dec_pending = 1'b1;
          if (sts.pending_one) begin
            state_next = has_byte ? S_BYTE : S_ACCEPT;
          end
        end
      end
      S_BYTE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = stc_pkg::OUT_BYTE_HELD;
          cmd.out_last = 1'b1;
          state_next   = S_ACCEPT;
        end
      end
      default: begin
        state_next = S_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_ACCEPT;
      has_byte <= 1'b0;
    end else begin
      state    <= state_next;
      has_byte <= has_byte_next;
    end
  end

  // Flushing must never start or continue with an empty count
  a_spaces_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_SPACES |-> !sts.pending_zero)
    else $error("space flush with no pending spaces");

  a_byte_held: assert property (@(posedge clk) disable iff (rst)
    state == S_BYTE |-> has_byte)
    else $error("byte state without a held byte");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("output register overwritten");

  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    acc && sts.end_item && sts.pending_zero |=> state == S_ACCEPT)
    else $error("empty end item left the accept state");

endmodule

// ----- hdl/space_run_to_tab_compressor.sv -----
// Top level of the space-run to tab compressor.
// Depends on stc_pkg, stc_ctrl and stc_datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    text_byte, end_of_text
//   out      output     out_valid/out_ready  out_byte, last_of_run
//   cfg      input      cfg_wr_en            cfg_wr_data (tab width)
//
// An item that makes zero or one result is dealt with as it is taken; one that
// releases n held spaces emits them (then its own byte, if any) one per cycle
// while the output register is free, through the single output register.
// Reset (rst, synchronous) clears column and space count, width returns to 8.
// A stalled output holds its item; input is taken only while the output
// register is empty or being read and no flush is under way.
`timescale 1ns / 1ps

module space_run_to_tab_compressor (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  stc_pkg::cmd_t    cmd;
  stc_pkg::status_t sts;

  stc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule
